// ----- rtl/piecewise_linear_table_interpolator_assert.svh -----
// ---------------------------------------------------------------------------
// piecewise linear table interpolator assertion macros
// concurrent checks on clock, disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PLTI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PLTI_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define PLTI_ASSERT_IMP(lbl, ante, cons)
`define PLTI_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/plti_pkg.sv -----
// ---------------------------------------------------------------------------
// plti_pkg
// types and codes of the piecewise linear table interpolator
// ---------------------------------------------------------------------------
package plti_pkg;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_FIND_Y = 2'd1;
   localparam logic [1:0] OP_FIND_X = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH_A,
      S_FETCH_B,
      S_TEST,
      S_REFETCH,
      S_SETUP,
      S_MUL,
      S_DIV,
      S_FINISH,
      S_RESPOND
   } state_type;

endpackage

// ----- rtl/plti_ram.sv -----
// ---------------------------------------------------------------------------
// plti_ram
// single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module plti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/piecewise_linear_table_interpolator.sv -----
// ---------------------------------------------------------------------------
// piecewise linear table interpolator
// Holds up to TABLE_DEPTH signed Q16.16 (x,y) points and answers find-y and
// find-x requests by a segment scan and linear interpolation. One request is
// handled at a time. A load or unused request is answered without a scan.
// A find request scans one segment per cycle through the table ram read
// port, and a find-x that extrapolates from the first segment refetches
// that segment. A zero numerator or divisor skips the multiply and divide.
// The response is held until rsp_tready is seen. The multiply is a
// shift-add unit, one bit a cycle, and the divide a restoring divider, one
// quotient bit a cycle. The table needs no clearing after reset.
// ---------------------------------------------------------------------------
module piecewise_linear_table_interpolator #(
   parameter int TABLE_DEPTH = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   // configuration: point_count
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data,
   // request: tdata = point_index, x_value, y_value, search_start, search_end
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   input  logic [((2*VALUE_WIDTH+26+7)/8)*8-1:0]           req_tdata,
   // request: tuser = operation
   input  logic [1:0]                                      req_tuser,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // response: tdata = result_value
   output logic [((VALUE_WIDTH+7)/8)*8-1:0]                rsp_tdata,
   // response: tuser = flat_segment, extrapolated
   output logic [1:0]                                      rsp_tuser
);

   import plti_pkg::*;

   `include "piecewise_linear_table_interpolator_assert.svh"

   localparam int W   = VALUE_WIDTH;
   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int CW  = (IW + 1 > 9) ? IW + 1 : 9;
   localparam int DW  = W + 1;
   localparam int PW  = 2 * W + 2;
   localparam int RW  = W + 2;
   localparam int SW  = W + 3;
   localparam int NW  = $clog2(PW);
   localparam int RSP_W = ((W + 7) / 8) * 8;

   localparam logic [PW-1:0] CAP = PW'(1) << (W + 1);
   localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

   function automatic logic same_side(input logic signed [DW-1:0] a,
                                      input logic signed [DW-1:0] b);
      return (a != '0) && (b != '0) && (a[DW-1] == b[DW-1]);
   endfunction

   // request fields
   logic [7:0]          f_idx;
   logic signed [W-1:0] f_x;
   logic signed [W-1:0] f_y;
   logic [8:0]          f_st;
   logic [8:0]          f_en;

   assign f_idx = req_tdata[7:0];
   assign f_x   = req_tdata[W+7:8];
   assign f_y   = req_tdata[2*W+7:W+8];
   assign f_st  = req_tdata[2*W+16:2*W+8];
   assign f_en  = req_tdata[2*W+25:2*W+17];

   state_type state_ff, state_in;

   logic [8:0]          point_count_ff;
   logic                find_x_ff;
   logic                refetch_ff;
   logic signed [W-1:0] q_ff;
   logic [IW-1:0]       st_ff, en_ff, i_ff;
   logic signed [W-1:0] prev_x_ff, prev_y_ff, cur_x_ff, cur_y_ff, sty_ff;
   logic                extra_ff, flat_ff, neg_ff;
   logic signed [W-1:0] base_ff;
   logic [PW-1:0]       a_ff, prod_ff;
   logic [DW-1:0]       b_ff, d_ff;
   logic [RW-1:0]       rem_ff;
   logic [NW-1:0]       cnt_ff;
   logic                rsp_tvalid_ff;
   logic signed [W-1:0] rsp_res_ff;
   logic                rsp_flat_ff, rsp_extra_ff;

   // table rams
   logic                accept;
   logic                wr_en;
   logic [IW-1:0]       rd_addr;
   logic signed [W-1:0] rd_x, rd_y;

   assign accept = req_tvalid && req_tready;
   assign wr_en  = accept && (req_tuser == OP_LOAD) && (CW'(f_idx) < CW'(TABLE_DEPTH));

   plti_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_x_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(IW'(f_idx)),
      .wr_data(f_x),
      .rd_addr(rd_addr),
      .rd_data(rd_x)
   );

   plti_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_y_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(IW'(f_idx)),
      .wr_data(f_y),
      .rd_addr(rd_addr),
      .rd_data(rd_y)
   );

   // search range clamping
   logic [CW-1:0] cnt_c, en_c, st_c;

   always_comb begin
      cnt_c = CW'(point_count_ff);
      if (cnt_c < CW'(2)) cnt_c = CW'(2);
      if (cnt_c > CW'(TABLE_DEPTH)) cnt_c = CW'(TABLE_DEPTH);
      if (f_en[8] || (CW'(f_en) > cnt_c - CW'(1))) begin
         en_c = cnt_c - CW'(1);
      end else begin
         en_c = CW'(f_en);
      end
      if (en_c < CW'(1)) en_c = CW'(1);
      st_c = f_st[8] ? '0 : CW'(f_st);
      if (st_c >= en_c) st_c = en_c - CW'(1);
   end

   // scan test
   logic signed [DW-1:0] side_a, side_b;
   logic                 same, go_on, above, pick_en;

   always_comb begin
      if (find_x_ff) begin
         side_a = DW'(rd_y) - DW'(q_ff);
         side_b = DW'(sty_ff) - DW'(q_ff);
      end else begin
         side_a = DW'(rd_x) - DW'(q_ff);
         side_b = DW'(prev_x_ff) - DW'(q_ff);
      end
      same    = same_side(side_a, side_b);
      go_on   = same && (i_ff < en_ff);
      above   = sty_ff > q_ff;
      // rd_y holds y at the range end when a find-x scan runs out
      pick_en = (sty_ff > rd_y) ? above : !above;
   end

   // segment setup
   logic signed [DW-1:0] dq, dn, den;
   logic signed [W-1:0]  base_w;
   logic [DW-1:0]        mag_a, mag_b, mag_d;

   always_comb begin
      if (find_x_ff) begin
         base_w = prev_x_ff;
         dq     = DW'(q_ff) - DW'(prev_y_ff);
         dn     = DW'(cur_x_ff) - DW'(prev_x_ff);
         den    = DW'(cur_y_ff) - DW'(prev_y_ff);
      end else begin
         base_w = prev_y_ff;
         dq     = DW'(q_ff) - DW'(prev_x_ff);
         dn     = DW'(cur_y_ff) - DW'(prev_y_ff);
         den    = DW'(cur_x_ff) - DW'(prev_x_ff);
      end
      mag_a = dq[DW-1]  ? DW'(-dq)  : DW'(dq);
      mag_b = dn[DW-1]  ? DW'(-dn)  : DW'(dn);
      mag_d = den[DW-1] ? DW'(-den) : DW'(den);
   end

   // divide step and final sum
   logic [RW-1:0]        shifted;
   logic                 qbit;
   logic [PW-1:0]        qsat;
   logic signed [SW-1:0] sum;
   logic signed [W-1:0]  res_w;

   always_comb begin
      shifted = {rem_ff[RW-2:0], prod_ff[PW-1]};
      qbit    = shifted >= RW'(d_ff);
      qsat    = (prod_ff > CAP) ? CAP : prod_ff;
      if (neg_ff) begin
         sum = SW'(base_ff) - SW'(qsat);
      end else begin
         sum = SW'(base_ff) + SW'(qsat);
      end
      if (sum > VMAX) begin
         res_w = W'(VMAX);
      end else if (sum < VMIN) begin
         res_w = W'(VMIN);
      end else begin
         res_w = W'(sum);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rd_addr    = i_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = !rsp_tvalid_ff;
            if (req_tvalid && !rsp_tvalid_ff) begin
               if ((req_tuser == OP_FIND_Y) || (req_tuser == OP_FIND_X)) begin
                  state_in = S_FETCH_A;
               end else begin
                  state_in = S_RESPOND;
               end
            end
         end
         S_FETCH_A: begin
            rd_addr  = i_ff - IW'(1);
            state_in = S_FETCH_B;
         end
         S_FETCH_B: begin
            rd_addr  = i_ff;
            state_in = refetch_ff ? S_REFETCH : S_TEST;
         end
         S_TEST: begin
            rd_addr = i_ff + IW'(1);
            if (!go_on) begin
               if (find_x_ff && same && !pick_en) begin
                  state_in = S_FETCH_A;
               end else begin
                  state_in = S_SETUP;
               end
            end
         end
         S_REFETCH: state_in = S_SETUP;
         S_SETUP: begin
            if ((mag_a == '0) || (mag_b == '0) || (mag_d == '0)) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (cnt_ff == NW'(DW - 1)) state_in = S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == NW'(PW - 1)) state_in = S_FINISH;
         end
         S_FINISH: state_in = S_RESPOND;
         S_RESPOND: begin
            if (rsp_tvalid_ff && rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 9'd2;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) point_count_ff <= csr_wr_data;
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end else if ((state_ff == S_FINISH) || (state_ff == S_IDLE && accept &&
                      (req_tuser == OP_LOAD || req_tuser == OP_NONE))) begin
            rsp_tvalid_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            find_x_ff    <= req_tuser == OP_FIND_X;
            refetch_ff   <= 1'b0;
            q_ff         <= (req_tuser == OP_FIND_X) ? f_y : f_x;
            st_ff        <= st_c[IW-1:0];
            en_ff        <= en_c[IW-1:0];
            i_ff         <= st_c[IW-1:0] + IW'(1);
            extra_ff     <= 1'b0;
            rsp_res_ff   <= '0;
            rsp_flat_ff  <= 1'b0;
            rsp_extra_ff <= 1'b0;
         end
         S_FETCH_A: ;
         S_FETCH_B: begin
            prev_x_ff <= rd_x;
            prev_y_ff <= rd_y;
            if (!refetch_ff) sty_ff <= rd_y;
         end
         S_TEST: begin
            if (go_on) begin
               prev_x_ff <= rd_x;
               prev_y_ff <= rd_y;
               i_ff      <= i_ff + IW'(1);
            end else begin
               cur_x_ff <= rd_x;
               cur_y_ff <= rd_y;
               extra_ff <= same;
               // find-x extrapolation off the first segment of the range
               if (find_x_ff && same && !pick_en) begin
                  i_ff       <= st_ff + IW'(1);
                  refetch_ff <= 1'b1;
               end
            end
         end
         S_REFETCH: begin
            cur_x_ff <= rd_x;
            cur_y_ff <= rd_y;
         end
         S_SETUP: begin
            base_ff <= base_w;
            neg_ff  <= dq[DW-1] != dn[DW-1];
            flat_ff <= mag_d == '0;
            a_ff    <= PW'(mag_a);
            b_ff    <= mag_b;
            d_ff    <= mag_d;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            if ((mag_a == '0) || (mag_b == '0)) begin
               prod_ff <= '0;
            end else if (mag_d == '0) begin
               prod_ff <= CAP;
            end else begin
               prod_ff <= '0;
            end
         end
         S_MUL: begin
            if (b_ff[0]) prod_ff <= prod_ff + a_ff;
            a_ff   <= a_ff << 1;
            b_ff   <= b_ff >> 1;
            cnt_ff <= (cnt_ff == NW'(DW - 1)) ? '0 : cnt_ff + NW'(1);
         end
         S_DIV: begin
            rem_ff  <= qbit ? shifted - RW'(d_ff) : shifted;
            prod_ff <= {prod_ff[PW-2:0], qbit};
            cnt_ff  <= cnt_ff + NW'(1);
         end
         S_FINISH: begin
            rsp_res_ff   <= res_w;
            rsp_flat_ff  <= flat_ff;
            rsp_extra_ff <= extra_ff;
         end
         S_RESPOND: ;
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'(unsigned'(rsp_res_ff));
   assign rsp_tuser  = {rsp_extra_ff, rsp_flat_ff};

   `PLTI_ASSERT_IMP(a_one_request, rsp_tvalid_ff, !req_tready)
   `PLTI_ASSERT_IMP(a_scan_in_range, state_ff == S_TEST, (i_ff <= en_ff) && (st_ff < en_ff))
   `PLTI_ASSERT_IMP(a_div_nonzero, state_ff == S_DIV, d_ff != '0)
   `PLTI_ASSERT_NXT(a_setup_next, state_ff == S_SETUP, state_ff == S_MUL || state_ff == S_FINISH)

endmodule
